### design/object_table_free_list_top_assert.svh
// assertion macros for the object table free list
`ifndef OBJECT_TABLE_FREE_LIST_TOP_ASSERT_SVH
`define OBJECT_TABLE_FREE_LIST_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define OTFL_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// consequent checked in the next cycle
`define OTFL_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### design/otfl_pkg.sv
`default_nettype none

package otfl_pkg;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_SWAP  = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_RESP,
		ST_RD_B,
		ST_WR_A,
		ST_WR_B
	} state_t;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_A,
		RD_B
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_CLEAR,
		WR_ALLOC,
		WR_FREE,
		WR_SWAP_A,
		WR_SWAP_B
	} wr_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FULL,
		RES_ALLOC,
		RES_FREE
	} res_t;

	typedef struct packed {
		logic    capture;
		logic    mem_rd;
		rd_sel_t rd_sel;
		logic    mem_wr;
		wr_sel_t wr_sel;
		logic    tmp_load;
		logic    head_load;
		logic    clr_step;
		logic    load_out;
		res_t    res_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_alloc;
		logic in_free;
		logic in_swap;
		logic head_empty;
		logic ia_ok;
		logic ib_ok;
		logic cur_alloc;
		logic clr_last;
		logic out_free;
	} ctl_sts_t;

endpackage

`default_nettype wire

### design/object_table_free_list_top.sv
// object table with the free list threaded through its own slots
// input channel in_valid/in_ready carries cmd, object_addr, index_a, index_b;
// output channel out_valid/out_ready carries status, slot_index, released_addr,
// exactly one result transaction per input transaction, in order
// allocate and free do one read and one write of the single port slot
// memory; the result is loaded into the output register with the write
// swap does two reads and two writes of the same port, and its result is
// loaded with the second write; out of range, table full and unused commands
// make no memory access
// one item is in work at a time; in_ready is high only between items
// after reset a clearing pass writes the initial chain with in_ready low;
// the free head starts at slot 0
// the result sits in an output register: a new item is taken while it waits,
// and that item holds its final step until out_ready frees the register
`default_nettype none
`include "object_table_free_list_top_assert.svh"

module object_table_free_list_top
	import otfl_pkg::*;
#(
	parameter int TABLE_SLOTS = 1024,
	parameter int ADDR_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] object_addr,
	input  wire logic [9:0]  index_a,
	input  wire logic [9:0]  index_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [9:0]       slot_index,
	output logic [31:0]      released_addr
);

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	otfl_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	otfl_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.object_addr   (object_addr),
		.index_a       (index_a),
		.index_b       (index_b),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.slot_index    (slot_index),
		.released_addr (released_addr),
		.ctl           (ctl),
		.sts           (sts)
	);

	`OTFL_ASSERT_SAME(a_single_port, ctl.mem_rd, !ctl.mem_wr, "slot memory read and written together")
	`OTFL_ASSERT_SAME(a_no_overwrite, ctl.load_out, !out_valid || out_ready, "result overwritten")
	`OTFL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`OTFL_ASSERT_SAME(a_no_take_in_clear, ctl.clr_step, !in_ready, "item taken during clearing pass")

endmodule

`default_nettype wire

### design/otfl_dp.sv
`default_nettype none

module otfl_dp
	import otfl_pkg::*;
#(
	parameter int TABLE_SLOTS = 1024,
	parameter int ADDR_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] object_addr,
	input  wire logic [9:0]  index_a,
	input  wire logic [9:0]  index_b,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic             status,
	output logic [9:0]       slot_index,
	output logic [31:0]      released_addr,
	input  wire ctl_cmd_t    ctl,
	output ctl_sts_t         sts
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int LINK_W = $clog2(TABLE_SLOTS + 1);
	localparam int W = (ADDR_BITS > LINK_W) ? ADDR_BITS : LINK_W;
	localparam int CW = (LINK_W > 10) ? LINK_W : 10;
	localparam int RW = (W > 32) ? W : 32;
	localparam int AKEEP = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [W-1:0] SLOTS_W = W'(TABLE_SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

	logic [W-1:0]      mem [TABLE_SLOTS];
	logic [W-1:0]      rd_q;
	logic [W-1:0]      tmp_q;
	logic [W-1:0]      addr_q;
	logic [W-1:0]      wr_data;
	logic [IDX_W-1:0]  ia_q;
	logic [IDX_W-1:0]  ib_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  mem_addr;
	logic [LINK_W-1:0] head_q;
	logic              alloc_q;
	logic [CW-1:0]     ia_c;
	logic [CW-1:0]     ib_c;
	logic [CW-1:0]     head_c;
	logic [RW-1:0]     rd_r;
	logic              next_ok;
	logic              status_q;
	logic [9:0]        slot_q;
	logic [31:0]       rel_q;
	logic              out_valid_q;

	assign ia_c = CW'(index_a);
	assign ib_c = CW'(index_b);
	assign head_c = CW'(head_q);
	assign rd_r = RW'(rd_q);
	// a popped link that is not a slot index empties the list
	assign next_ok = rd_q < SLOTS_W;

	assign sts.in_alloc = cmd == CMD_ALLOC;
	assign sts.in_free = cmd == CMD_FREE;
	assign sts.in_swap = cmd == CMD_SWAP;
	assign sts.head_empty = head_q == NULL_LINK;
	assign sts.ia_ok = ia_c < SLOTS_C;
	assign sts.ib_ok = ib_c < SLOTS_C;
	assign sts.cur_alloc = alloc_q;
	assign sts.clr_last = clr_q == LAST_IDX;
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		mem_addr = clr_q;
		wr_data = W'(clr_q) + W'(1'b1);
		if (ctl.mem_wr) begin
			unique case (ctl.wr_sel)
				WR_CLEAR: begin
					mem_addr = clr_q;
					wr_data = W'(clr_q) + W'(1'b1);
				end
				WR_ALLOC: begin
					mem_addr = head_q[IDX_W-1:0];
					wr_data = addr_q;
				end
				WR_FREE: begin
					mem_addr = ia_q;
					wr_data = W'(head_q);
				end
				WR_SWAP_A: begin
					mem_addr = ia_q;
					wr_data = rd_q;
				end
				WR_SWAP_B: begin
					mem_addr = ib_q;
					wr_data = tmp_q;
				end
				default: begin
					mem_addr = clr_q;
				end
			endcase
		end else begin
			unique case (ctl.rd_sel)
				RD_HEAD: mem_addr = head_q[IDX_W-1:0];
				RD_A:    mem_addr = ia_c[IDX_W-1:0];
				RD_B:    mem_addr = ib_q;
				default: mem_addr = clr_q;
			endcase
		end
	end

	// single port slot memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[mem_addr] <= wr_data;
		end
		if (ctl.mem_rd) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			ia_q <= ia_c[IDX_W-1:0];
			ib_q <= ib_c[IDX_W-1:0];
			addr_q <= W'(object_addr[AKEEP-1:0]);
			alloc_q <= cmd == CMD_ALLOC;
		end
		if (ctl.tmp_load) begin
			tmp_q <= rd_q;
		end
		if (ctl.load_out) begin
			unique case (ctl.res_sel)
				RES_ZERO: begin
					status_q <= 1'b0;
					slot_q <= '0;
					rel_q <= '0;
				end
				RES_FULL: begin
					status_q <= 1'b1;
					slot_q <= '0;
					rel_q <= '0;
				end
				RES_ALLOC: begin
					status_q <= 1'b0;
					slot_q <= head_c[9:0];
					rel_q <= '0;
				end
				RES_FREE: begin
					status_q <= 1'b0;
					slot_q <= '0;
					rel_q <= rd_r[31:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.head_load) begin
				if (alloc_q) begin
					head_q <= next_ok ? rd_q[LINK_W-1:0] : NULL_LINK;
				end else begin
					head_q <= LINK_W'(ia_q);
				end
			end
			if (ctl.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot_index = slot_q;
	assign released_addr = rel_q;

endmodule

`default_nettype wire

### design/otfl_ctl.sv
`default_nettype none

module otfl_ctl
	import otfl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		ctl = '0;
		unique case (state_q)
			ST_INIT: begin
				// clearing pass rebuilds the free chain one slot a cycle
				ctl.mem_wr = 1'b1;
				ctl.wr_sel = WR_CLEAR;
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					priority if (sts.in_alloc && !sts.head_empty) begin
						ctl.mem_rd = 1'b1;
						ctl.rd_sel = RD_HEAD;
						state_d = ST_WRITE;
					end else if (sts.in_free && sts.ia_ok) begin
						ctl.mem_rd = 1'b1;
						ctl.rd_sel = RD_A;
						state_d = ST_WRITE;
					end else if (sts.in_swap && sts.ia_ok && sts.ib_ok) begin
						ctl.mem_rd = 1'b1;
						ctl.rd_sel = RD_A;
						state_d = ST_RD_B;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					ctl.mem_wr = 1'b1;
					ctl.wr_sel = sts.cur_alloc ? WR_ALLOC : WR_FREE;
					ctl.head_load = 1'b1;
					ctl.load_out = 1'b1;
					ctl.res_sel = sts.cur_alloc ? RES_ALLOC : RES_FREE;
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				// table full, index out of range or unused command
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					ctl.res_sel = sts.cur_alloc ? RES_FULL : RES_ZERO;
					state_d = ST_IDLE;
				end
			end
			ST_RD_B: begin
				ctl.mem_rd = 1'b1;
				ctl.rd_sel = RD_B;
				ctl.tmp_load = 1'b1;
				state_d = ST_WR_A;
			end
			ST_WR_A: begin
				ctl.mem_wr = 1'b1;
				ctl.wr_sel = WR_SWAP_A;
				state_d = ST_WR_B;
			end
			ST_WR_B: begin
				if (sts.out_free) begin
					ctl.mem_wr = 1'b1;
					ctl.wr_sel = WR_SWAP_B;
					ctl.load_out = 1'b1;
					ctl.res_sel = RES_ZERO;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import otfl_pkg::*;

	localparam int SLOTS = 1024;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
	localparam int RANDOM_ITEMS = 1030;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct packed {
		logic        status;
		logic [9:0]  slot_index;
		logic [31:0] released_addr;
	} result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] addr;
		logic [9:0]  idx_a;
		logic [9:0]  idx_b;
		logic        fixed;
		result_t     res;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [31:0] object_addr;
	logic [9:0]  index_a;
	logic [9:0]  index_b;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [9:0]  slot_index;
	logic [31:0] released_addr;

	// model of the slot table and the head of the free list
	bit [31:0] slot_mem [SLOTS];
	bit [10:0] free_head;
	int        live_slots[$];
	result_t   pending_results[$];

	int  errors;
	int  results_seen;
	int  full_replies;
	int  cmd_count [4];
	int  idle_cycles;
	bit  no_gaps;
	bit  long_hold_done;

	cmd_row_t directed_rows [22] = '{
		'{CMD_ALLOC, 32'hFFFF_FFFF, 10'd0,    10'd0,    1'b1, '{STATUS_OK, 10'd0, 32'd0}},
		'{CMD_ALLOC, 32'h0000_0000, 10'd1023, 10'd1023, 1'b1, '{STATUS_OK, 10'd1, 32'd0}},
		'{CMD_FREE,  32'h0000_0000, 10'd0,    10'd1023, 1'b1,
			'{STATUS_OK, 10'd0, 32'hFFFF_FFFF}},
		'{CMD_FREE,  32'hFFFF_FFFF, 10'd1,    10'd0,    1'b1, '{STATUS_OK, 10'd0, 32'd0}},
		// freeing a slot that is already on the list hands back its link
		'{CMD_FREE,  32'h0000_0000, 10'd1000, 10'd0,    1'b1, '{STATUS_OK, 10'd0, 32'd1001}},
		'{CMD_SWAP,  32'h0000_0000, 10'd1023, 10'd0,    1'b1, '{STATUS_OK, 10'd0, 32'd0}},
		'{CMD_NONE,  32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1, '{STATUS_OK, 10'd0, 32'd0}},
		'{CMD_ALLOC, 32'h1234_5678, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'hAAAA_AAAA, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'h5555_5555, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'hFFFF_FFFF, 10'd0,    10'd0,    1'b1, '{STATUS_FULL, 10'd0, 32'd0}},
		'{CMD_FREE,  32'h0000_0000, 10'd1023, 10'd0,    1'b0, '0},
		// plant an object address in the free chain
		'{CMD_SWAP,  32'h0000_0000, 10'd1023, 10'd1000, 1'b0, '0},
		'{CMD_ALLOC, 32'h0000_0005, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'h0000_0000, 10'd0,    10'd0,    1'b1, '{STATUS_FULL, 10'd0, 32'd0}},
		'{CMD_FREE,  32'h0000_0000, 10'd1023, 10'd0,    1'b0, '0},
		'{CMD_FREE,  32'h0000_0000, 10'd1,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'h8000_0000, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'h0000_03FF, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_SWAP,  32'h0000_0000, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_FREE,  32'h0000_0000, 10'd0,    10'd0,    1'b0, '0},
		'{CMD_ALLOC, 32'h0000_0001, 10'd0,    10'd0,    1'b0, '0}
	};

	object_table_free_list_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.object_addr   (object_addr),
		.index_a       (index_a),
		.index_b       (index_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_index    (slot_index),
		.released_addr (released_addr)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic result_t apply_command(logic [1:0] op, logic [31:0] addr,
			logic [9:0] ia, logic [9:0] ib);
		result_t r;
		bit [31:0] held;
		r = '0;
		case (op)
			CMD_ALLOC: begin
				if (free_head >= SLOTS) begin
					r.status = STATUS_FULL;
				end else begin
					r.slot_index = free_head[9:0];
					held = slot_mem[r.slot_index];
					// anything that is not a slot index ends the list
					free_head = (held < SLOTS) ? held[10:0] : 11'(SLOTS);
					slot_mem[r.slot_index] = addr;
				end
			end
			CMD_FREE: begin
				r.released_addr = slot_mem[ia];
				slot_mem[ia] = 32'(free_head);
				free_head = 11'(ia);
			end
			CMD_SWAP: begin
				held = slot_mem[ia];
				slot_mem[ia] = slot_mem[ib];
				slot_mem[ib] = held;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic push_item(input logic [1:0] op, input logic [31:0] addr,
			input logic [9:0] ia, input logic [9:0] ib,
			input logic fixed, input result_t fixed_res);
		result_t pred;
		int hits[$];
		int gap;
		in_valid <= 1'b1;
		cmd <= op;
		object_addr <= addr;
		index_a <= ia;
		index_b <= ib;
		do @(posedge clk); while (in_ready !== 1'b1);
		pred = apply_command(op, addr, ia, ib);
		pending_results.push_back(fixed ? fixed_res : pred);
		cmd_count[op]++;
		if (op == CMD_ALLOC && pred.status == STATUS_FULL)
			full_replies++;
		if (op == CMD_ALLOC && pred.status == STATUS_OK) begin
			hits = live_slots.find_first_index(s) with (s == pred.slot_index);
			if (hits.size() == 0)
				live_slots.push_back(pred.slot_index);
		end else if (op == CMD_FREE) begin
			hits = live_slots.find_first_index(s) with (s == ia);
			if (hits.size() != 0)
				live_slots.delete(hits[0]);
		end
		@(negedge clk);
		gap = no_gaps ? 0 : idle_length();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin : stimulus
		logic [1:0]  op;
		logic [31:0] addr;
		logic [9:0]  ia;
		logic [9:0]  ib;
		int          pick;
		int          alloc_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		object_addr = '0;
		index_a = '0;
		index_b = '0;
		for (int n = 0; n < SLOTS; n++)
			slot_mem[n] = n + 1;
		free_head = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			push_item(directed_rows[k].op, directed_rows[k].addr, directed_rows[k].idx_a,
				directed_rows[k].idx_b, directed_rows[k].fixed, directed_rows[k].res);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				// let the block drain completely before going on
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_results.size() != 0);
			end
			no_gaps = ((i / 60) % 4) == 3;
			alloc_pct = ((i / 150) % 2) ? 55 : 35;
			pick = $urandom_range(0, 99);
			// small addresses look like valid links once they reach the chain
			addr = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, SLOTS)) : $urandom;
			ia = $urandom_range(0, SLOTS - 1);
			ib = $urandom_range(0, SLOTS - 1);
			if (pick < alloc_pct) begin
				op = CMD_ALLOC;
			end else if (pick < 75 && live_slots.size() != 0) begin
				op = CMD_FREE;
				ia = live_slots[$urandom_range(0, live_slots.size() - 1)];
			end else if (pick < 85 && live_slots.size() > 1) begin
				op = CMD_SWAP;
				ia = live_slots[$urandom_range(0, live_slots.size() - 1)];
				ib = live_slots[$urandom_range(0, live_slots.size() - 1)];
			end else begin
				op = 2'($urandom_range(CMD_FREE, CMD_NONE));
			end
			push_item(op, addr, ia, ib, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("ran %0d alloc, %0d free, %0d swap and %0d unused commands",
			cmd_count[CMD_ALLOC], cmd_count[CMD_FREE], cmd_count[CMD_SWAP], cmd_count[CMD_NONE]);
		$display("checked %0d results, %0d of them table full", results_seen, full_replies);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= 300) begin
				// hold off long enough for the block to back up into its input
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			stall = ((results_seen / 150) % 2) ? 0 : idle_length();
			if (stall == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing outstanding: status %0d slot_index %0d released_addr %h",
					status, slot_index, released_addr);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
					errors++;
				end
				if (released_addr !== want.released_addr) begin
					$error("released_addr: expected %h, got %h", want.released_addr, released_addr);
					errors++;
				end
			end
		end
	end

	// covers the clearing pass after reset and the long receiver hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
